// ----- rtl/core/software_timer_deadline_table_defines.svh -----
// Assertion macros shared by the timer deadline table RTL.
`ifndef SOFTWARE_TIMER_DEADLINE_TABLE_DEFINES_SVH
`define SOFTWARE_TIMER_DEADLINE_TABLE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define STDT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define STDT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/stdt_pkg.sv -----
// Types and constants shared by the timer deadline table modules.
`default_nettype none
package stdt_pkg;

	localparam int SLOT_W = 6;
	localparam int DL_W   = 64;
	localparam int HND_W  = 32;

	localparam logic [DL_W-1:0] ALL_ONES = '1;

	localparam logic CMD_ADD    = 1'b0;
	localparam logic CMD_EXPIRE = 1'b1;

	localparam logic [1:0] STATUS_ADDED  = 2'd0;
	localparam logic [1:0] STATUS_FULL   = 2'd1;
	localparam logic [1:0] STATUS_EXPIRE = 2'd2;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		logic [DL_W-1:0]   deadline;
		logic [HND_W-1:0]  handle;
	} mem_wr_t;

endpackage
`default_nettype wire

// ----- rtl/core/stdt_store.sv -----
// Deadline and handle memories of the timer table, one write and one read port.
`default_nettype none
module stdt_store import stdt_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  wire logic              clk,
	input  wire mem_wr_t           wr,
	input  wire logic              rd_en,
	input  wire logic [SLOT_W-1:0] rd_addr,
	output logic      [DL_W-1:0]   rd_deadline,
	output logic      [HND_W-1:0]  rd_handle
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DL_W-1:0]  deadline_mem [DEPTH];
	logic [HND_W-1:0] handle_mem   [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			deadline_mem[wr.addr[IDX_W-1:0]] <= wr.deadline;
			handle_mem[wr.addr[IDX_W-1:0]]   <= wr.handle;
		end
	end

	// Read data is registered: it appears in the cycle after an address given with rd_en high.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_deadline <= deadline_mem[rd_addr[IDX_W-1:0]];
			rd_handle   <= handle_mem[rd_addr[IDX_W-1:0]];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/software_timer_deadline_table.sv -----
// Top level of the software timer deadline table.
//
// This block keeps up to SLOT_COUNT software timers behind one hardware
// compare register. A word is accepted when start is high and busy is low.
// An add word (command 0) stores the handle in the lowest free slot with the
// deadline now + delay_seconds * tick_frequency, wrapping at 64 bits, and
// answers with one result word; busy stays high through the multiply and
// add states and falls as the result appears. An expire word (command 1)
// walks the deadline memory one slot per cycle through its read port, with
// busy high through the scan and final states. It returns one word per
// active slot whose deadline is at or before now, in rising slot
// order, and the final word carries the new compare value (the earliest
// remaining deadline, or all ones) with last set. When nothing expires a single
// word with fired low carries the compare value. Result words are shown for
// exactly one cycle with done high; the receiver cannot stall them, so it must
// take every word on the cycle it appears. Write tick_frequency through cfg_we
// and cfg_wdata only while busy is low and no result is still due.
`default_nettype none
`include "software_timer_deadline_table_defines.svh"
module software_timer_deadline_table import stdt_pkg::*; #(
	parameter int SLOT_COUNT = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Command side.
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              command,
	input  wire logic [DL_W-1:0]   now,
	input  wire logic [15:0]       delay_seconds,
	input  wire logic [HND_W-1:0]  handle,
	// Result side.
	output logic                   done,
	output logic      [1:0]        status,
	output logic                   fired,
	output logic      [SLOT_W-1:0] slot,
	output logic      [HND_W-1:0]  fired_handle,
	output logic                   compare_set,
	output logic      [DL_W-1:0]   compare_value,
	output logic                   last,
	// Configuration.
	input  wire logic              cfg_we,
	input  wire logic [31:0]       cfg_wdata
);

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);
	localparam int PROD_W = 48;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_ADD  = 3'd2;
	localparam logic [2:0] ST_SCAN = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]            state_q;
	logic [31:0]           tick_q;
	logic [DL_W-1:0]       now_q;
	logic [15:0]           delay_q;
	logic [HND_W-1:0]      hnd_q;
	logic [PROD_W-1:0]     prod_s1;

	// Per-slot valid bits; the memories themselves hold no valid state.
	logic [SLOT_COUNT-1:0] active_q;
	logic [DL_W-1:0]       pend_dl_q;
	logic                  pend_v_q;

	// Expire scan: read issue counter, then one compare stage.
	logic [CNT_W-1:0]      rd_cnt_q;
	logic                  vld_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [DL_W-1:0]       best_q;
	logic                  any_q;

	// The most recent expired slot is held back so that the final one can
	// carry the compare value and the last flag.
	logic                  held_v_q;
	logic [IDX_W-1:0]      held_slot_q;
	logic [HND_W-1:0]      held_hnd_q;

	logic                  done_q;
	logic [1:0]            status_q;
	logic                  fired_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [HND_W-1:0]      fhnd_q;
	logic                  cset_q;
	logic [DL_W-1:0]       cval_q;
	logic                  last_q;

	logic                  accept;
	logic [SLOT_COUNT-1:0] free_vec;
	logic [SLOT_COUNT-1:0] free_onehot;
	logic [IDX_W-1:0]      free_idx;
	logic                  free_any;
	logic [DL_W-1:0]       dl_add;
	logic                  set_add;
	mem_wr_t               mem_wr;
	logic                  rd_en;
	logic [SLOT_W-1:0]     rd_addr;
	logic [DL_W-1:0]       rd_dl_s1;
	logic [HND_W-1:0]      rd_hd_s1;
	logic                  stg_act;
	logic                  stg_fire;
	logic                  stg_min;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// Lowest free slot: isolate the lowest set bit of the free vector, then
	// encode the one-hot result.
	assign free_vec    = ~active_q;
	assign free_onehot = free_vec & (~free_vec + SLOT_COUNT'(1));
	assign free_any    = |free_vec;

	always_comb begin
		free_idx = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (free_onehot[i]) begin
				free_idx = free_idx | IDX_W'(i);
			end
		end
	end

	assign dl_add  = now_q + {{(DL_W-PROD_W){1'b0}}, prod_s1};
	assign set_add = !pend_v_q || (dl_add < pend_dl_q);

	always_comb begin
		mem_wr.en       = (state_q == ST_ADD) && free_any;
		mem_wr.addr     = SLOT_W'(free_idx);
		mem_wr.deadline = dl_add;
		mem_wr.handle   = hnd_q;
	end

	assign rd_en   = (state_q == ST_SCAN) && (rd_cnt_q < CNT_W'(SLOT_COUNT));
	assign rd_addr = SLOT_W'(rd_cnt_q[IDX_W-1:0]);

	stdt_store #(
		.DEPTH(SLOT_COUNT)
	) u_store (
		.clk        (clk),
		.wr         (mem_wr),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_deadline(rd_dl_s1),
		.rd_handle  (rd_hd_s1)
	);

	// Compare stage of the scan. A slot is due when its deadline is at or
	// before now; otherwise it competes for the earliest remaining deadline.
	assign stg_act  = vld_s1 && active_q[idx_s1];
	assign stg_fire = stg_act && (rd_dl_s1 <= now_q);
	assign stg_min  = stg_act && !stg_fire && (!any_q || (rd_dl_s1 < best_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tick_q      <= 32'd10000000;
			now_q       <= '0;
			delay_q     <= '0;
			hnd_q       <= '0;
			prod_s1     <= '0;
			active_q    <= '0;
			pend_dl_q   <= '0;
			pend_v_q    <= 1'b0;
			rd_cnt_q    <= '0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			best_q      <= ALL_ONES;
			any_q       <= 1'b0;
			held_v_q    <= 1'b0;
			held_slot_q <= '0;
			held_hnd_q  <= '0;
			done_q      <= 1'b0;
			status_q    <= STATUS_ADDED;
			fired_q     <= 1'b0;
			slot_q      <= '0;
			fhnd_q      <= '0;
			cset_q      <= 1'b0;
			cval_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= 1'b0;

			if (cfg_we) begin
				tick_q <= cfg_wdata;
			end

			// Scan compare stage runs whenever a read came back.
			if (stg_fire) begin
				active_q[idx_s1] <= 1'b0;
				held_v_q         <= 1'b1;
				held_slot_q      <= idx_s1;
				held_hnd_q       <= rd_hd_s1;
				if (held_v_q) begin
					done_q   <= 1'b1;
					status_q <= STATUS_EXPIRE;
					fired_q  <= 1'b1;
					slot_q   <= SLOT_W'(held_slot_q);
					fhnd_q   <= held_hnd_q;
					cset_q   <= 1'b0;
					cval_q   <= '0;
					last_q   <= 1'b0;
				end
			end
			if (stg_min) begin
				best_q <= rd_dl_s1;
				any_q  <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						now_q   <= now;
						delay_q <= delay_seconds;
						hnd_q   <= handle;
						if (command == CMD_ADD) begin
							state_q <= ST_MUL;
						end else begin
							// The compare is parked while the scan runs.
							pend_v_q  <= 1'b0;
							pend_dl_q <= '0;
							rd_cnt_q  <= '0;
							best_q    <= ALL_ONES;
							any_q     <= 1'b0;
							held_v_q  <= 1'b0;
							state_q   <= ST_SCAN;
						end
					end
				end
				ST_MUL: begin
					prod_s1 <= PROD_W'(delay_q) * PROD_W'(tick_q);
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					done_q  <= 1'b1;
					fired_q <= 1'b0;
					fhnd_q  <= '0;
					last_q  <= 1'b1;
					if (free_any) begin
						active_q[free_idx] <= 1'b1;
						status_q           <= STATUS_ADDED;
						slot_q             <= SLOT_W'(free_idx);
						cset_q             <= set_add;
						cval_q             <= set_add ? dl_add : '0;
						if (set_add) begin
							pend_dl_q <= dl_add;
							pend_v_q  <= 1'b1;
						end
					end else begin
						status_q <= STATUS_FULL;
						slot_q   <= '0;
						cset_q   <= 1'b0;
						cval_q   <= '0;
					end
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (rd_en) begin
						rd_cnt_q <= rd_cnt_q + CNT_W'(1);
						vld_s1   <= 1'b1;
						idx_s1   <= rd_cnt_q[IDX_W-1:0];
					end else begin
						// The last slot is in the compare stage this cycle.
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					done_q    <= 1'b1;
					status_q  <= STATUS_EXPIRE;
					fired_q   <= held_v_q;
					slot_q    <= held_v_q ? SLOT_W'(held_slot_q) : '0;
					fhnd_q    <= held_v_q ? held_hnd_q : '0;
					cset_q    <= 1'b1;
					cval_q    <= any_q ? best_q : ALL_ONES;
					last_q    <= 1'b1;
					pend_v_q  <= any_q;
					pend_dl_q <= any_q ? best_q : '0;
					held_v_q  <= 1'b0;
					state_q   <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign fired         = fired_q;
	assign slot          = slot_q;
	assign fired_handle  = fhnd_q;
	assign compare_set   = cset_q;
	assign compare_value = cval_q;
	assign last          = last_q;

	// Add and full results always close their word.
	`STDT_ASSERT_NOW(a_add_is_last, clk, arst_n,
		done && (status == STATUS_ADDED || status == STATUS_FULL), last,
		"add result without last")
	// A fired report that is not last never reprograms the compare.
	`STDT_ASSERT_NOW(a_mid_report_no_compare, clk, arst_n,
		done && fired && !last, !compare_set && status == STATUS_EXPIRE,
		"intermediate expire report carries a compare value")
	// No compare-stage work may be in flight once the block is idle.
	`STDT_ASSERT_NOW(a_idle_stage_empty, clk, arst_n,
		state_q == ST_IDLE, !vld_s1 && !held_v_q,
		"scan stage busy while idle")
	// An accepted word makes the block busy on the next cycle.
	`STDT_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy,
		"accepted word did not raise busy")
	// The final expire result leaves the pending flag matching the compare.
	`STDT_ASSERT_NEXT(a_fin_pending, clk, arst_n, state_q == ST_FIN,
		done && last && (pend_v_q == (compare_value != ALL_ONES || any_q)),
		"expire end left inconsistent pending state")

endmodule
`default_nettype wire
